// ===== design/tlbcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbcr_pkg
// Shared sizes, command codes and sequencer states for the translation buffer
// ----------------------------------------------------------------------------
package tlbcr_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int PAGE_BITS  = 8;
  localparam int FRAME_BITS = 8;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_ADD    = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

endpackage

// ===== design/tlbcr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbcr_in_if
// Request channel: command, page, frame and mode flag with valid/ready
// ----------------------------------------------------------------------------
interface tlbcr_in_if;
  logic                  valid;
  logic                  ready;
  logic                  command;
  tlbcr_pkg::page_t      page;
  tlbcr_pkg::frame_t     frame;
  logic                  mode_flag;

  modport source (output valid, command, page, frame, mode_flag, input ready);
  modport sink   (input valid, command, page, frame, mode_flag, output ready);
endinterface

// ===== design/tlbcr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbcr_out_if
// Response channel: hit flag and found frame with valid/ready
// ----------------------------------------------------------------------------
interface tlbcr_out_if;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  tlbcr_pkg::frame_t     found_frame;

  modport source (output valid, hit, found_frame, input ready);
  modport sink   (input valid, hit, found_frame, output ready);
endinterface

// ===== design/tlb_with_clock_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_with_clock_replacement
// Fully associative translation buffer with enhanced clock victim selection
// ----------------------------------------------------------------------------
// channel  dir  payload                                  words
// req      in   command, page, frame, mode_flag          one per item
// rsp      out  hit, found_frame                         one per item
//
// one comparator walks the entries, one entry per cycle
// lookup: scans from slot zero over up to ENTRIES entries (stops at the first valid match)
// add: scans from the hand over up to ENTRIES entries, then a write state fills the victim slot
// req.ready needs idle and a free or draining response register; a stalled
// response holds in its register; rst empties all entries, hand at slot zero
// ----------------------------------------------------------------------------
module tlb_with_clock_replacement (
  input  logic              clk,
  input  logic              rst,
  tlbcr_in_if.sink          req,
  tlbcr_out_if.source       rsp
);

  // entry storage
  tlbcr_pkg::page_t                  entry_page  [tlbcr_pkg::ENTRIES];
  tlbcr_pkg::frame_t                 entry_frame [tlbcr_pkg::ENTRIES];
  logic [tlbcr_pkg::ENTRIES-1:0]     entry_valid;
  logic [tlbcr_pkg::ENTRIES-1:0]     entry_readonly;
  logic [tlbcr_pkg::ENTRIES-1:0]     entry_referenced;
  tlbcr_pkg::idx_t                   hand;

  // sequencer
  tlbcr_pkg::state_t state, state_next;
  tlbcr_pkg::idx_t   idx;
  tlbcr_pkg::idx_t   cnt;
  tlbcr_pkg::idx_t   victim;
  logic              best;
  logic              good;

  // latched request
  logic              cmd_r;
  tlbcr_pkg::page_t  page_r;
  tlbcr_pkg::frame_t frame_r;
  logic              flag_r;

  // response register
  logic              res_valid;
  logic              res_hit;
  tlbcr_pkg::frame_t res_frame;

  logic              accept;
  logic              scan_last;
  logic              cmp_eq;
  logic              lk_hit;
  logic              add_take;
  logic              add_best;
  logic              add_good;
  logic              add_ro;
  logic              add_clear;
  logic              scan_stop;
  tlbcr_pkg::idx_t   idx_inc;
  tlbcr_pkg::idx_t   victim_inc;

  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == tlbcr_pkg::S_IDLE) && (!res_valid || rsp.ready);
  assign rsp.valid   = res_valid;
  assign rsp.hit     = res_hit;
  assign rsp.found_frame = res_frame;

  assign scan_last  = (cnt == tlbcr_pkg::idx_t'(tlbcr_pkg::ENTRIES - 1));
  assign idx_inc    = (idx == tlbcr_pkg::idx_t'(tlbcr_pkg::ENTRIES - 1)) ?
                      '0 : idx + 1'b1;
  assign victim_inc = (victim == tlbcr_pkg::idx_t'(tlbcr_pkg::ENTRIES - 1)) ?
                      '0 : victim + 1'b1;

  // the shared compare unit: page for a lookup, frame for an add
  always_comb begin
    if (cmd_r == tlbcr_pkg::CMD_ADD) begin
      cmp_eq = (entry_frame[idx] == frame_r);
    end else begin
      cmp_eq = (entry_page[idx] == page_r);
    end
  end

  // scan decisions for the entry under idx
  always_comb begin
    lk_hit    = 1'b0;
    add_take  = 1'b0;
    add_best  = 1'b0;
    add_good  = 1'b0;
    add_ro    = 1'b0;
    add_clear = 1'b0;
    if (state == tlbcr_pkg::S_SCAN) begin
      if (cmd_r == tlbcr_pkg::CMD_ADD) begin
        if (!entry_valid[idx] || cmp_eq) begin
          add_take = 1'b1;
        end else if (entry_readonly[idx] && !entry_referenced[idx]) begin
          add_best = 1'b1;
        end else if (!best && !entry_referenced[idx]) begin
          add_good = 1'b1;
        end else if (!good && entry_readonly[idx]) begin
          add_ro = 1'b1;
        end else begin
          add_clear = 1'b1;
        end
      end else begin
        lk_hit = entry_valid[idx] && cmp_eq;
      end
    end
  end

  assign scan_stop = lk_hit || add_take || scan_last;

  always_comb begin
    state_next = state;
    case (state)
      tlbcr_pkg::S_IDLE: begin
        if (accept) state_next = tlbcr_pkg::S_SCAN;
      end
      tlbcr_pkg::S_SCAN: begin
        if (scan_stop) begin
          state_next = (cmd_r == tlbcr_pkg::CMD_ADD) ? tlbcr_pkg::S_WRITE
                                                     : tlbcr_pkg::S_IDLE;
        end
      end
      tlbcr_pkg::S_WRITE: state_next = tlbcr_pkg::S_IDLE;
      default:            state_next = tlbcr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tlbcr_pkg::S_IDLE;
      entry_valid      <= '0;
      entry_readonly   <= '0;
      entry_referenced <= '0;
      hand             <= '0;
      res_valid        <= 1'b0;
      idx              <= '0;
      cnt              <= '0;
      victim           <= '0;
      best             <= 1'b0;
      good             <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && rsp.ready) res_valid <= 1'b0;

      if (accept) begin
        cmd_r   <= req.command;
        page_r  <= req.page;
        frame_r <= req.frame;
        flag_r  <= req.mode_flag;
        cnt     <= '0;
        best    <= 1'b0;
        good    <= 1'b0;
        victim  <= hand;
        idx     <= (req.command == tlbcr_pkg::CMD_ADD) ? hand : '0;
      end

      if (state == tlbcr_pkg::S_SCAN) begin
        idx <= idx_inc;
        cnt <= cnt + 1'b1;
        if (lk_hit) begin
          entry_readonly[idx]   <= flag_r;
          entry_referenced[idx] <= 1'b1;
        end
        if (add_take || add_best || add_good || add_ro) victim <= idx;
        if (add_best) best <= 1'b1;
        if (add_good) good <= 1'b1;
        if (add_clear) entry_referenced[idx] <= 1'b0;
        // lookup finishes here, hit or miss
        if (cmd_r == tlbcr_pkg::CMD_LOOKUP && scan_stop) begin
          res_valid <= 1'b1;
          res_hit   <= lk_hit;
          res_frame <= lk_hit ? entry_frame[idx] : '0;
        end
      end

      if (state == tlbcr_pkg::S_WRITE) begin
        entry_page[victim]       <= page_r;
        entry_frame[victim]      <= frame_r;
        entry_valid[victim]      <= 1'b1;
        entry_readonly[victim]   <= flag_r;
        entry_referenced[victim] <= 1'b1;
        hand                     <= victim_inc;
        res_valid                <= 1'b1;
        res_hit                  <= 1'b0;
        res_frame                <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != tlbcr_pkg::S_IDLE) |-> !req.ready)
    else $error("request taken while the scan is busy");

  a_miss_zero_frame: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_hit) |-> (res_frame == '0))
    else $error("miss or add response carries a frame");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == tlbcr_pkg::S_WRITE) |=> (entry_valid[$past(victim)] &&
                                        entry_referenced[$past(victim)]))
    else $error("victim slot not filled after write");

  a_hand_moves: assert property (@(posedge clk) disable iff (rst)
    (state == tlbcr_pkg::S_WRITE) |=> (hand == $past(victim_inc)))
    else $error("hand not placed after the victim");

  a_add_ends_in_write: assert property (@(posedge clk) disable iff (rst)
    (state == tlbcr_pkg::S_SCAN && cmd_r == tlbcr_pkg::CMD_ADD && scan_stop)
      |=> (state == tlbcr_pkg::S_WRITE))
    else $error("add scan ended without a write");
`endif

endmodule

// ===== test/tlbcr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbcr_checker
// Watches the request and response channels of the translation buffer. It
// keeps its own copy of the entries and the clock hand, works out the
// translation due for every accepted request word and compares each accepted
// response word with the oldest one still owed.
// ----------------------------------------------------------------------------
module tlbcr_checker (
  input  logic  clk,
  input  logic  rst,
  tlbcr_in_if   req,
  tlbcr_out_if  rsp,
  output int    fail_count,
  output int    pending,
  output int    lookups,
  output int    hits,
  output int    adds,
  output int    empty_fills,
  output int    frame_reuses
);

  typedef struct packed {
    logic              hit;
    tlbcr_pkg::frame_t found_frame;
  } xlat_t;

  tlbcr_pkg::page_t  tbl_page  [tlbcr_pkg::ENTRIES];
  tlbcr_pkg::frame_t tbl_frame [tlbcr_pkg::ENTRIES];
  logic              tbl_valid [tlbcr_pkg::ENTRIES];
  logic              tbl_ro    [tlbcr_pkg::ENTRIES];
  logic              tbl_ref   [tlbcr_pkg::ENTRIES];
  int                clock_hand;

  xlat_t  owed_xlat_q[$];
  int     rsp_count;

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] response %0d: %s got %0d expected %0d", $realtime, rsp_count, what,
             got, want);
    fail_count++;
  endtask

  task automatic clear_table();
    for (int i = 0; i < tlbcr_pkg::ENTRIES; i++) begin
      tbl_page[i]  = '0;
      tbl_frame[i] = '0;
      tbl_valid[i] = 1'b0;
      tbl_ro[i]    = 1'b0;
      tbl_ref[i]   = 1'b0;
    end
    clock_hand = 0;
  endtask

  // enhanced clock victim choice, then write the new entry
  function automatic void place_entry(tlbcr_pkg::page_t pg, tlbcr_pkg::frame_t fr,
                                      logic ro);
    int  victim;
    int  s;
    int  k;
    bit  best;
    bit  good;
    victim = clock_hand;
    best   = 1'b0;
    good   = 1'b0;
    for (k = 0; k < tlbcr_pkg::ENTRIES; k++) begin
      s = (clock_hand + k) % tlbcr_pkg::ENTRIES;
      if (!tbl_valid[s] || tbl_frame[s] == fr) begin
        victim = s;
        if (!tbl_valid[s]) empty_fills++;
        else frame_reuses++;
        break;
      end else if (tbl_ro[s] && !tbl_ref[s]) begin
        victim = s;
        best   = 1'b1;
      end else if (!best && !tbl_ref[s]) begin
        victim = s;
        good   = 1'b1;
      end else if (!good && tbl_ro[s]) begin
        victim = s;
      end else begin
        tbl_ref[s] = 1'b0;
      end
    end
    clock_hand        = (victim + 1) % tlbcr_pkg::ENTRIES;
    tbl_page[victim]  = pg;
    tbl_frame[victim] = fr;
    tbl_valid[victim] = 1'b1;
    tbl_ro[victim]    = ro;
    tbl_ref[victim]   = 1'b1;
  endfunction

  function automatic xlat_t translate(logic cmd, tlbcr_pkg::page_t pg,
                                      tlbcr_pkg::frame_t fr, logic flag);
    xlat_t res;
    res = '0;
    if (cmd == tlbcr_pkg::CMD_ADD) begin
      place_entry(pg, fr, flag);
      adds++;
    end else begin
      lookups++;
      for (int i = 0; i < tlbcr_pkg::ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_page[i] == pg) begin
          tbl_ro[i]       = flag;
          tbl_ref[i]      = 1'b1;
          res.hit         = 1'b1;
          res.found_frame = tbl_frame[i];
          hits++;
          break;
        end
      end
    end
    return res;
  endfunction

  initial begin
    fail_count   = 0;
    pending      = 0;
    lookups      = 0;
    hits         = 0;
    adds         = 0;
    empty_fills  = 0;
    frame_reuses = 0;
    rsp_count    = 0;
    clear_table();
  end

  always @(posedge clk) begin
    xlat_t want;
    if (rst) begin
      clear_table();
      owed_xlat_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (owed_xlat_q.size() == 0) begin
          $display("[%0t] response %0d arrived with nothing owed", $realtime, rsp_count);
          fail_count++;
        end else begin
          want = owed_xlat_q.pop_front();
          if (rsp.hit !== want.hit)
            report_mismatch("hit", int'(rsp.hit), int'(want.hit));
          if (rsp.found_frame !== want.found_frame)
            report_mismatch("found_frame", int'(rsp.found_frame),
                            int'(want.found_frame));
        end
        rsp_count++;
      end
      if (req.valid && req.ready)
        owed_xlat_q.push_back(translate(req.command, req.page, req.frame, req.mode_flag));
    end
    pending = owed_xlat_q.size();
  end

endmodule

// ===== test/tlb_with_clock_replacement_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_with_clock_replacement_test
// Drives lookup and add words into the translation buffer: a directed fill
// and corner pass, then random traffic over small page and frame pools so
// that hits, evictions and frame reuse are frequent, under three idle
// patterns, a long response hold-off and a full drain. The checker beside
// the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tlb_with_clock_replacement_test;

  localparam int PHASE_ITEMS  = 417;
  localparam int POOL_PAGES   = 24;
  localparam int POOL_FRAMES  = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 90;

  logic clk;
  logic rst;

  tlbcr_in_if  req_if ();
  tlbcr_out_if rsp_if ();

  int fail_count;
  int pending;
  int lookups;
  int hits;
  int adds;
  int empty_fills;
  int frame_reuses;

  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  int                cycles;
  tlbcr_pkg::page_t  page_pool  [POOL_PAGES];
  tlbcr_pkg::frame_t frame_pool [POOL_FRAMES];

  tlb_with_clock_replacement u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  tlbcr_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req_if),
    .rsp          (rsp_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .lookups      (lookups),
    .hits         (hits),
    .adds         (adds),
    .empty_fills  (empty_fills),
    .frame_reuses (frame_reuses)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d responses still owed", cycles, pending);
    $display("tlb_with_clock_replacement_test failed");
    $finish;
  end

  // response side: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_req(tlbcr_pkg::cmd_t cmd, tlbcr_pkg::page_t pg,
                          tlbcr_pkg::frame_t fr, logic flag);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.page      <= pg;
    req_if.frame     <= fr;
    req_if.mode_flag <= flag;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // leaves the request channel idle until every owed response has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic refill_pools();
    foreach (page_pool[i]) page_pool[i] = tlbcr_pkg::page_t'($urandom);
    foreach (frame_pool[i]) frame_pool[i] = tlbcr_pkg::frame_t'($urandom);
  endtask

  task automatic random_req();
    tlbcr_pkg::cmd_t   cmd;
    tlbcr_pkg::page_t  pg;
    tlbcr_pkg::frame_t fr;
    cmd = ($urandom_range(99) < 40) ? tlbcr_pkg::CMD_ADD : tlbcr_pkg::CMD_LOOKUP;
    pg  = ($urandom_range(99) < 85) ? page_pool[$urandom_range(POOL_PAGES - 1)]
                                    : tlbcr_pkg::page_t'($urandom);
    fr  = ($urandom_range(99) < 30) ? frame_pool[$urandom_range(POOL_FRAMES - 1)]
                                    : tlbcr_pkg::frame_t'($urandom);
    send_req(cmd, pg, fr, logic'($urandom_range(1)));
  endtask

  initial begin
    send_idle_pct = 15;
    recv_idle_pct = 49;
    hold_req      = 1'b0;
    rst              <= 1'b1;
    req_if.valid     <= 1'b0;
    req_if.command   <= tlbcr_pkg::CMD_LOOKUP;
    req_if.page      <= '0;
    req_if.frame     <= '0;
    req_if.mode_flag <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty buffer must miss, even on page zero
    send_req(tlbcr_pkg::CMD_LOOKUP, 8'h00, 8'h00, 1'b0);
    send_req(tlbcr_pkg::CMD_LOOKUP, 8'hff, 8'hff, 1'b1);
    // fill every slot, pages 0..255 in steps, frames descending
    for (int i = 0; i < tlbcr_pkg::ENTRIES; i++)
      send_req(tlbcr_pkg::CMD_ADD, tlbcr_pkg::page_t'(i * 17),
               tlbcr_pkg::frame_t'(255 - i * 17), logic'(i[0]));
    send_req(tlbcr_pkg::CMD_LOOKUP, 8'h00, 8'h00, 1'b1);
    send_req(tlbcr_pkg::CMD_LOOKUP, 8'hff, 8'h00, 1'b0);
    send_req(tlbcr_pkg::CMD_LOOKUP, 8'h03, 8'hff, 1'b0);
    // frame already held by a slot far from the hand
    send_req(tlbcr_pkg::CMD_ADD, 8'h03, 8'h00, 1'b1);
    // full scan: no empty slot and no slot holding this frame
    send_req(tlbcr_pkg::CMD_ADD, 8'h04, 8'h32, 1'b0);
    // second entry for a page already present, lowest slot must win
    send_req(tlbcr_pkg::CMD_ADD, 8'h55, 8'h4d, 1'b0);
    send_req(tlbcr_pkg::CMD_LOOKUP, 8'h55, 8'hff, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 15 : 0;
      refill_pools();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 200) hold_req = 1'b1;
        if (phase == 1 && n == 200) drain();
        if (n % 100 == 50) refill_pools();
        random_req();
      end
      drain();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d words: %0d adds (%0d into empty slots, %0d frame reuses)",
             adds + lookups, adds, empty_fills, frame_reuses);
    $display("and %0d lookups with %0d hits, in %0d cycles", lookups, hits, cycles);
    if (fail_count == 0) begin
      $display("tlb_with_clock_replacement_test passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tlb_with_clock_replacement_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tlbcr_pkg.sv
design/tlbcr_in_if.sv
design/tlbcr_out_if.sv
design/tlb_with_clock_replacement.sv
test/tlbcr_checker.sv
test/tlb_with_clock_replacement_test.sv
